[design/mcst_pkg.sv]
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared types and constants for the multi-channel timer bank.
// ----------------------------------------------------------------------------
package mcst_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int CHANNEL_W       = 3;
    localparam int DATA_W          = 32;
    localparam int MASK_W          = 8;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_OPEN      = 3'd1,
        CMD_CLOSE     = 3'd2,
        CMD_CLOSE_ALL = 3'd3,
        CMD_START     = 3'd4,
        CMD_STOP      = 3'd5,
        CMD_SET_NEXT  = 3'd6,
        CMD_QUERY     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_OPEN     = 2'd1,
        ST_ALREADY_OPEN = 2'd2,
        ST_ZERO_TIMEOUT = 2'd3
    } t_status;

    // per-channel control strobes, at most one besides tick is set
    typedef struct packed {
        logic tick;
        logic open;
        logic close;
        logic start;
        logic stop;
        logic set_next;
    } t_chan_ctrl;

    typedef struct packed {
        logic open;
        logic running;
        logic expired;
    } t_chan_stat;

endpackage

[design/mcst_chan.sv]
// ----------------------------------------------------------------------------
// mcst_chan
// One timer channel: state registers, tick counter and expiry compare.
// ----------------------------------------------------------------------------
module mcst_chan
    import mcst_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_chan_ctrl             i_ctrl,
    input  logic [COUNT_WIDTH-1:0] i_timeout,
    input  logic                   i_oneshot,
    output t_chan_stat             o_stat,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [COUNT_WIDTH-1:0] o_remaining
);

    logic                   r_open, r_running, r_oneshot;
    logic [COUNT_WIDTH-1:0] r_tmo, r_pend, r_cnt;
    logic                   n_open, n_running, n_oneshot;
    logic [COUNT_WIDTH-1:0] n_tmo, n_pend, n_cnt;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic                   w_due;
    logic                   w_hit;

    // w_due: the next tick would expire this channel (registered state only)
    assign w_inc = r_cnt + COUNT_WIDTH'(1);
    assign w_due = r_open && r_running && (w_inc == r_tmo);
    assign w_hit = i_ctrl.tick && w_due;

    always_comb begin
        n_open    = r_open;
        n_running = r_running;
        n_oneshot = r_oneshot;
        n_tmo     = r_tmo;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        if (i_ctrl.close) begin
            n_open    = 1'b0;
            n_running = 1'b0;
            n_oneshot = 1'b0;
            n_tmo     = '0;
            n_pend    = '0;
            n_cnt     = '0;
        end else if (i_ctrl.open) begin
            n_open    = 1'b1;
            n_running = 1'b0;
            n_oneshot = i_oneshot;
            n_tmo     = '0;
            n_pend    = '0;
            n_cnt     = '0;
        end else if (i_ctrl.start) begin
            n_tmo     = i_timeout;
            n_cnt     = '0;
            n_running = 1'b1;
        end else if (i_ctrl.stop) begin
            n_running = 1'b0;
        end else if (i_ctrl.set_next) begin
            n_pend = i_timeout;
        end else if (i_ctrl.tick && r_open && r_running) begin
            n_cnt = w_hit ? '0 : w_inc;
            if (w_hit) begin
                if (r_pend != '0) begin
                    n_tmo  = r_pend;
                    n_pend = '0;
                end
                if (r_oneshot) begin
                    n_running = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_running <= 1'b0;
            r_oneshot <= 1'b0;
            r_tmo     <= '0;
            r_pend    <= '0;
            r_cnt     <= '0;
        end else begin
            r_open    <= n_open;
            r_running <= n_running;
            r_oneshot <= n_oneshot;
            r_tmo     <= n_tmo;
            r_pend    <= n_pend;
            r_cnt     <= n_cnt;
        end
    end

    assign o_stat.open    = r_open;
    assign o_stat.running = r_running;
    assign o_stat.expired = w_due;
    assign o_count        = r_cnt;
    assign o_remaining    = r_tmo - r_cnt;

endmodule

[design/multi_channel_soft_timer.sv]
// ----------------------------------------------------------------------------
// multi_channel_soft_timer
// Command-driven bank of timer channels with tick, open/close, start/stop,
// pending next timeout and query, reporting an expired mask and status.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes the input register, then the result
//   register; a stalled output holds both until it drains.
// Throughput: one request per cycle unless the output stalls; each channel
//   owns a counter and comparator; a tick updates the whole bank on execute.
// Reset: synchronous active-low i_rst_n clears all channels and both
//   pipeline valids; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer
    import mcst_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [2:0]           i_command,
    input  logic [CHANNEL_W-1:0] i_channel,
    input  logic [DATA_W-1:0]    i_timeout,
    input  logic                 i_oneshot,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [MASK_W-1:0]    o_expired_mask,
    output logic [DATA_W-1:0]    o_elapsed,
    output logic [DATA_W-1:0]    o_remaining,
    output logic                 o_is_running,
    output logic [1:0]           o_status
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // ---------------- input register ----------------
    logic                   r_in_valid;
    t_cmd                   r_cmd;
    logic [CHANNEL_W-1:0]   r_ch;
    logic [COUNT_WIDTH-1:0] r_tmo;
    logic                   r_os;

    // ---------------- result register ----------------
    logic                   r_out_valid;
    logic [MASK_W-1:0]      r_mask;
    logic [DATA_W-1:0]      r_elapsed;
    logic [DATA_W-1:0]      r_remaining;
    logic                   r_running;
    t_status                r_status;

    logic                   w_exec;
    logic                   w_ch_valid;
    logic [IDX_W-1:0]       w_idx;
    logic                   w_is_open;
    logic                   w_tmo_zero;

    t_chan_ctrl             w_ctrl  [CHANNELS];
    t_chan_stat             w_stat  [CHANNELS];
    logic [COUNT_WIDTH-1:0] w_count [CHANNELS];
    logic [COUNT_WIDTH-1:0] w_rem   [CHANNELS];
    logic [CHANNELS-1:0]    w_open_vec;
    logic [CHANNELS-1:0]    w_run_vec;
    logic [MASK_W-1:0]      w_exp_mask;

    // decoded strobes, to the addressed channel; tick and close all go to all
    logic                   n_tick, n_open, n_close, n_close_all;
    logic                   n_start, n_stop, n_set_next;
    logic [MASK_W-1:0]      n_mask;
    logic [DATA_W-1:0]      n_elapsed, n_remaining;
    logic                   n_running;
    t_status                n_status;

    // Execute when the result register is free or being drained.
    assign w_exec     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_exec;

    // An index beyond the bank reads as closed; opening it gives ST_NOT_OPEN.
    assign w_ch_valid = (32'(r_ch) < CHANNELS);
    assign w_idx      = IDX_W'(r_ch);
    assign w_is_open  = w_ch_valid && w_open_vec[w_idx];
    assign w_tmo_zero = (r_tmo == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= t_cmd'(i_command);
            r_ch  <= i_channel;
            r_tmo <= i_timeout[COUNT_WIDTH-1:0];   // taken modulo 2^COUNT_WIDTH
            r_os  <= i_oneshot;
        end
    end

    // ---------------- command decode and status ----------------
    always_comb begin
        n_tick      = 1'b0;
        n_open      = 1'b0;
        n_close     = 1'b0;
        n_close_all = 1'b0;
        n_start     = 1'b0;
        n_stop      = 1'b0;
        n_set_next  = 1'b0;
        n_mask      = '0;
        n_elapsed   = '0;
        n_remaining = '0;
        n_running   = 1'b0;
        n_status    = ST_OK;
        case (r_cmd)
            CMD_TICK: begin
                n_tick = 1'b1;
                n_mask = w_exp_mask;
            end
            CMD_OPEN: begin
                if (!w_ch_valid) begin
                    n_status = ST_NOT_OPEN;
                end else if (w_is_open) begin
                    n_status = ST_ALREADY_OPEN;
                end else begin
                    n_open = 1'b1;
                end
            end
            CMD_CLOSE: begin
                if (!w_is_open) n_status = ST_NOT_OPEN;
                else            n_close  = 1'b1;
            end
            CMD_CLOSE_ALL: begin
                n_close_all = 1'b1;
            end
            CMD_START: begin
                if (!w_is_open)      n_status = ST_NOT_OPEN;
                else if (w_tmo_zero) n_status = ST_ZERO_TIMEOUT;
                else                 n_start  = 1'b1;
            end
            CMD_STOP: begin
                if (!w_is_open) n_status = ST_NOT_OPEN;
                else            n_stop   = 1'b1;
            end
            CMD_SET_NEXT: begin
                if (!w_is_open)      n_status   = ST_NOT_OPEN;
                else if (w_tmo_zero) n_status   = ST_ZERO_TIMEOUT;
                else                 n_set_next = 1'b1;
            end
            CMD_QUERY: begin
                if (!w_is_open) begin
                    n_status = ST_NOT_OPEN;
                end else begin
                    n_elapsed   = DATA_W'(w_count[w_idx]);
                    n_remaining = DATA_W'(w_rem[w_idx]);
                    n_running   = w_run_vec[w_idx];
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // ---------------- channel bank ----------------
    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        logic w_sel;
        assign w_sel = w_exec && (32'(r_ch) == c);

        assign w_ctrl[c].tick     = w_exec && n_tick;
        assign w_ctrl[c].open     = w_sel && n_open;
        assign w_ctrl[c].close    = (w_sel && n_close) || (w_exec && n_close_all);
        assign w_ctrl[c].start    = w_sel && n_start;
        assign w_ctrl[c].stop     = w_sel && n_stop;
        assign w_ctrl[c].set_next = w_sel && n_set_next;

        mcst_chan #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_chan (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl[c]),
            .i_timeout   (r_tmo),
            .i_oneshot   (r_os),
            .o_stat      (w_stat[c]),
            .o_count     (w_count[c]),
            .o_remaining (w_rem[c])
        );

        assign w_open_vec[c] = w_stat[c].open;
        assign w_run_vec[c]  = w_stat[c].running;
    end

    // Only the first eight channels are visible in the expired mask.
    // A channel flags expiry when its next tick would hit the timeout.
    for (genvar m = 0; m < MASK_W; m++) begin : g_mask
        if (m < CHANNELS) begin : g_live
            assign w_exp_mask[m] = w_stat[m].expired;
        end else begin : g_none
            assign w_exp_mask[m] = 1'b0;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_mask      <= n_mask;
            r_elapsed   <= n_elapsed;
            r_remaining <= n_remaining;
            r_running   <= n_running;
            r_status    <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_expired_mask = r_mask;
    assign o_elapsed      = r_elapsed;
    assign o_remaining    = r_remaining;
    assign o_is_running   = r_running;
    assign o_status       = r_status;

    // ---------------- assertions ----------------
    a_run_needs_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_run_vec & ~w_open_vec) == '0)
        else $error("channel running while closed");

    a_close_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_cmd == CMD_CLOSE_ALL) |=> (w_open_vec == '0))
        else $error("channel still open after close all");

    a_open_adds_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && r_cmd == CMD_OPEN && n_status == ST_OK) |=>
        ($countones(w_open_vec) == $past($countones(w_open_vec)) + 1))
        else $error("successful open did not open exactly one channel");

    a_fail_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
        (o_elapsed == '0 && o_remaining == '0 && !o_is_running && o_expired_mask == '0))
        else $error("rejected request carries nonzero result fields");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled without a full pipeline");

endmodule
